[rtl/gradient_noise_3d_core_defines.svh]
// ----------------------------------------------------------------------------
// gradient noise 3d core assertion macros
// concurrent check wrappers, empty bodies for synthesis
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_3D_CORE_DEFINES_SVH
`define GRADIENT_NOISE_3D_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define GN3D_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gn3d check failed");
`define GN3D_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gn3d check failed");
`else
`define GN3D_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GN3D_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/gn3d_pkg.sv]
// ----------------------------------------------------------------------------
// gn3d_pkg
// shared types and constants of the gradient noise core
// ----------------------------------------------------------------------------
package gn3d_pkg;

    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 16;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } t_gn3d_kind;

    typedef struct packed {
        logic full;
        logic empty;
    } t_gn3d_qstat;

    typedef struct packed {
        logic clearing;
    } t_gn3d_bstat;

endpackage

[rtl/gn3d_if.sv]
// ----------------------------------------------------------------------------
// gn3d channel interfaces
// valid/ready channels for input items and noise results
// ----------------------------------------------------------------------------
interface gn3d_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [gn3d_pkg::BYTE_W-1:0]         table_index;
    logic [gn3d_pkg::BYTE_W-1:0]         table_value;
    logic signed [gn3d_pkg::COORD_W-1:0] x_coord;
    logic signed [gn3d_pkg::COORD_W-1:0] y_coord;
    logic signed [gn3d_pkg::COORD_W-1:0] z_coord;

    modport source (output valid, kind, table_index, table_value, x_coord, y_coord, z_coord,
                    input ready);
    modport sink (input valid, kind, table_index, table_value, x_coord, y_coord, z_coord,
                  output ready);
endinterface

interface gn3d_out_if #(parameter int FRAC_BITS = 16);
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink (input valid, noise_value, output ready);
endinterface

[rtl/gn3d_ram.sv]
// ----------------------------------------------------------------------------
// gn3d_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module gn3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

[rtl/gn3d_queue.sv]
// ----------------------------------------------------------------------------
// gn3d_queue
// short fifo between the classifier and the evaluation pipeline
// ----------------------------------------------------------------------------
module gn3d_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_data,
    output gn3d_pkg::t_gn3d_qstat o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic [CW-1:0]    n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
        end
        n_cnt = CW'(r_cnt + CW'(i_push) - CW'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

[rtl/gn3d_front.sv]
// ----------------------------------------------------------------------------
// gn3d_front
// input transfer, item decode and coordinate split into cell and fraction
// ----------------------------------------------------------------------------
module gn3d_front #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
) (
    gn3d_in_if.sink               i_in,
    input  gn3d_pkg::t_gn3d_qstat i_qstat,
    input  gn3d_pkg::t_gn3d_bstat i_bstat,
    output logic                  o_push,
    output logic [1+4*$clog2(TABLE_SIZE)+gn3d_pkg::BYTE_W+3*FRAC_BITS-1:0] o_item
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int F  = FRAC_BITS;
    localparam int XW = 2 * gn3d_pkg::COORD_W;

    gn3d_pkg::t_gn3d_kind   kind;
    logic [IW-1:0]          idx;
    logic [XW-1:0]          ext_x;
    logic [XW-1:0]          ext_y;
    logic [XW-1:0]          ext_z;

    assign kind  = gn3d_pkg::t_gn3d_kind'(i_in.kind);
    assign idx   = IW'(i_in.table_index);

    // sign extend so the floor cell can be taken at any fraction width
    assign ext_x = XW'(i_in.x_coord);
    assign ext_y = XW'(i_in.y_coord);
    assign ext_z = XW'(i_in.z_coord);

    assign i_in.ready = !i_qstat.full && !i_bstat.clearing;
    assign o_push     = i_in.valid && i_in.ready;

    assign o_item = {kind == gn3d_pkg::KIND_EVAL, idx, i_in.table_value,
                     ext_x[F +: IW], ext_y[F +: IW], ext_z[F +: IW],
                     ext_x[F-1:0], ext_y[F-1:0], ext_z[F-1:0]};

endmodule

[rtl/gn3d_back.sv]
// ----------------------------------------------------------------------------
// gn3d_back
// table lookup chain, quintic fade, gradients, trilinear blend, result fifo
// ----------------------------------------------------------------------------
module gn3d_back #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_head_valid,
    input  logic [1+4*$clog2(TABLE_SIZE)+gn3d_pkg::BYTE_W+3*FRAC_BITS-1:0] i_item,
    output logic                  o_pop,
    gn3d_out_if.source            o_out,
    output gn3d_pkg::t_gn3d_bstat o_status
);

    localparam int IW  = $clog2(TABLE_SIZE);
    localparam int F   = FRAC_BITS;
    localparam int W   = F + 8;
    localparam int PW  = 2 * W;
    localparam int BW  = gn3d_pkg::BYTE_W;
    localparam int OD  = gn3d_pkg::OUT_DEPTH;
    localparam int OAW = $clog2(OD);
    localparam int CW  = $clog2(OD + 1);

    localparam logic signed [W-1:0]  ONE  = W'(64'd1 << F);
    localparam logic signed [W-1:0]  C10  = W'(64'd10 << F);
    localparam logic signed [W-1:0]  C15  = W'(64'd15 << F);
    localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (F - 1));

    function automatic logic signed [PW-1:0] mul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [PW-1:0] ea;
        logic signed [PW-1:0] eb;
        ea = a;
        eb = b;
        return ea * eb;
    endfunction

    function automatic logic signed [W-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = (p + HALF) >>> F;
        return W'(s);
    endfunction

    function automatic logic signed [W-1:0] grad(input logic [3:0] h,
                                                 input logic signed [W-1:0] gx,
                                                 input logic signed [W-1:0] gy,
                                                 input logic signed [W-1:0] gz);
        logic signed [W-1:0] u;
        logic signed [W-1:0] v;
        u = (h < 4'd8) ? gx : gy;
        if (h < 4'd4) begin
            v = gy;
        end else if (h == 4'd12 || h == 4'd14) begin
            v = gx;
        end else begin
            v = gz;
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // head of queue
    logic          h_kind;
    logic [IW-1:0] h_idx;
    logic [BW-1:0] h_val;
    logic [IW-1:0] h_cx;
    logic [IW-1:0] h_cy;
    logic [IW-1:0] h_cz;
    logic [F-1:0]  h_fx;
    logic [F-1:0]  h_fy;
    logic [F-1:0]  h_fz;

    assign {h_kind, h_idx, h_val, h_cx, h_cy, h_cz, h_fx, h_fy, h_fz} = i_item;

    // control
    logic          r_clr;
    logic [IW-1:0] r_clr_cnt;
    logic [10:1]   r_vld;
    logic          r_ld1;
    logic          r_ld2;
    logic [CW-1:0] r_inflight;
    logic [CW-1:0] r_ocnt;
    logic [OAW-1:0] r_owr;
    logic [OAW-1:0] r_ord;
    logic [F:0]    r_ofifo [OD];

    logic issue;
    logic issue_eval;
    logic issue_load;
    logic credit_ok;
    logic owr;
    logic ord;

    assign credit_ok  = ({1'b0, r_inflight} + {1'b0, r_ocnt}) < (CW + 1)'(OD);
    assign issue      = i_head_valid && !r_clr &&
                        (gn3d_pkg::t_gn3d_kind'(h_kind) == gn3d_pkg::KIND_LOAD || credit_ok);
    assign issue_eval = issue && gn3d_pkg::t_gn3d_kind'(h_kind) == gn3d_pkg::KIND_EVAL;
    assign issue_load = issue && gn3d_pkg::t_gn3d_kind'(h_kind) == gn3d_pkg::KIND_LOAD;
    assign o_pop      = issue;
    assign owr        = r_vld[10];
    assign ord        = o_out.valid && o_out.ready;

    assign o_status.clearing = r_clr;

    // stage payload registers
    logic [IW-1:0]        r1_idx, r2_idx;
    logic [BW-1:0]        r1_val, r2_val;
    logic [IW-1:0]        r1_cy, r1_cz, r2_cz;
    logic signed [W-1:0]  r1_t [3];
    logic signed [W-1:0]  r2_t [3];
    logic signed [W-1:0]  r3_t [3];
    logic signed [PW-1:0] r1_pa [3];
    logic signed [PW-1:0] r1_pd [3];
    logic signed [PW-1:0] r2_pc [3];
    logic signed [PW-1:0] r2_pe [3];
    logic signed [PW-1:0] r3_pr [3];
    logic signed [W-1:0]  r4_g [8];
    logic signed [W-1:0]  r4_fd [3];
    logic signed [PW-1:0] r5_p [4];
    logic signed [W-1:0]  r5_b [4];
    logic signed [W-1:0]  r5_v, r5_w, r6_v, r6_w, r7_w, r8_w;
    logic signed [W-1:0]  r6_m [4];
    logic signed [PW-1:0] r7_p [2];
    logic signed [W-1:0]  r7_b [2];
    logic signed [W-1:0]  r8_m [2];
    logic signed [PW-1:0] r9_p;
    logic signed [W-1:0]  r9_b;
    logic signed [W-1:0]  r10_res;

    // next values
    logic signed [W-1:0]  n1_t [3];
    logic signed [PW-1:0] n1_pa [3];
    logic signed [PW-1:0] n1_pd [3];
    logic signed [PW-1:0] n2_pc [3];
    logic signed [PW-1:0] n2_pe [3];
    logic signed [PW-1:0] n3_pr [3];
    logic signed [W-1:0]  n4_g [8];
    logic signed [W-1:0]  n4_fd [3];
    logic signed [PW-1:0] n5_p [4];
    logic signed [W-1:0]  n6_m [4];
    logic signed [PW-1:0] n7_p [2];
    logic signed [W-1:0]  n8_m [2];
    logic signed [PW-1:0] n9_p;
    logic signed [W-1:0]  n10_res;
    logic signed [W-1:0]  fin;
    logic [F:0]           n_noise;

    // table copies: one at the first lookup level, two at the second, four at the third
    logic          we1, we2, we3;
    logic [IW-1:0] wa1, wa2, wa3;
    logic [BW-1:0] wd1, wd2, wd3;
    logic [BW-1:0] rd1_0, rd1_1;
    logic [BW-1:0] rd2_0 [2];
    logic [BW-1:0] rd2_1 [2];
    logic [BW-1:0] rd3_0 [4];
    logic [BW-1:0] rd3_1 [4];
    logic [IW-1:0] ad2 [2];
    logic [IW-1:0] ad3 [4];

    assign we1 = r_clr || issue_load;
    assign wa1 = r_clr ? r_clr_cnt : h_idx;
    assign wd1 = r_clr ? BW'(r_clr_cnt) : h_val;
    assign we2 = r_clr || r_ld1;
    assign wa2 = r_clr ? r_clr_cnt : r1_idx;
    assign wd2 = r_clr ? BW'(r_clr_cnt) : r1_val;
    assign we3 = r_clr || r_ld2;
    assign wa3 = r_clr ? r_clr_cnt : r2_idx;
    assign wd3 = r_clr ? BW'(r_clr_cnt) : r2_val;

    gn3d_ram #(.WIDTH(BW), .DEPTH(TABLE_SIZE)) u_ram1 (
        .i_clk    (i_clk),
        .i_we     (we1),
        .i_waddr  (wa1),
        .i_wdata  (wd1),
        .i_raddr0 (h_cx),
        .i_raddr1 (IW'(h_cx + 1'b1)),
        .o_rdata0 (rd1_0),
        .o_rdata1 (rd1_1)
    );

    assign ad2[0] = IW'(IW'(rd1_0) + r1_cy);
    assign ad2[1] = IW'(IW'(rd1_1) + r1_cy);

    for (genvar j = 0; j < 2; j++) begin : g_lvl2
        gn3d_ram #(.WIDTH(BW), .DEPTH(TABLE_SIZE)) u_ram2 (
            .i_clk    (i_clk),
            .i_we     (we2),
            .i_waddr  (wa2),
            .i_wdata  (wd2),
            .i_raddr0 (ad2[j]),
            .i_raddr1 (IW'(ad2[j] + 1'b1)),
            .o_rdata0 (rd2_0[j]),
            .o_rdata1 (rd2_1[j])
        );
    end

    // aa, ba, ab, bb
    assign ad3[0] = IW'(IW'(rd2_0[0]) + r2_cz);
    assign ad3[1] = IW'(IW'(rd2_0[1]) + r2_cz);
    assign ad3[2] = IW'(IW'(rd2_1[0]) + r2_cz);
    assign ad3[3] = IW'(IW'(rd2_1[1]) + r2_cz);

    for (genvar k = 0; k < 4; k++) begin : g_lvl3
        gn3d_ram #(.WIDTH(BW), .DEPTH(TABLE_SIZE)) u_ram3 (
            .i_clk    (i_clk),
            .i_we     (we3),
            .i_waddr  (wa3),
            .i_wdata  (wd3),
            .i_raddr0 (ad3[k]),
            .i_raddr1 (IW'(ad3[k] + 1'b1)),
            .o_rdata0 (rd3_0[k]),
            .o_rdata1 (rd3_1[k])
        );
    end

    // datapath
    always_comb begin
        logic signed [W-1:0] a6;
        logic signed [W-1:0] fb;
        logic signed [W-1:0] fdd;
        logic signed [W-1:0] fc;
        logic signed [W-1:0] fe;
        logic signed [W-1:0] fr;
        logic signed [W-1:0] gx;
        logic signed [W-1:0] gy;
        logic signed [W-1:0] gz;
        logic [BW-1:0]       hs;

        n1_t[0] = W'(h_fx);
        n1_t[1] = W'(h_fy);
        n1_t[2] = W'(h_fz);
        for (int i = 0; i < 3; i++) begin
            a6       = W'(n1_t[i] * 6) - C15;
            n1_pa[i] = mul(n1_t[i], a6);
            n1_pd[i] = mul(n1_t[i], n1_t[i]);
            fb       = rnd(r1_pa[i]) + C10;
            fdd      = rnd(r1_pd[i]);
            n2_pc[i] = mul(r1_t[i], fb);
            n2_pe[i] = mul(fdd, r1_t[i]);
            fc       = rnd(r2_pc[i]);
            fe       = rnd(r2_pe[i]);
            n3_pr[i] = mul(fe, fc);
            fr       = rnd(r3_pr[i]);
            if (fr < 0) begin
                fr = '0;
            end else if (fr > ONE) begin
                fr = ONE;
            end
            n4_fd[i] = fr;
        end

        // corner bit 0 is x, bit 1 is y, bit 2 is z
        for (int i = 0; i < 8; i++) begin
            gx      = ((i & 1) != 0) ? r3_t[0] - ONE : r3_t[0];
            gy      = ((i & 2) != 0) ? r3_t[1] - ONE : r3_t[1];
            gz      = ((i & 4) != 0) ? r3_t[2] - ONE : r3_t[2];
            hs      = (i < 4) ? rd3_0[i & 3] : rd3_1[i & 3];
            n4_g[i] = grad(hs[3:0], gx, gy, gz);
        end

        for (int k = 0; k < 4; k++) begin
            n5_p[k] = mul(r4_fd[0], r4_g[2*k+1] - r4_g[2*k]);
            n6_m[k] = r5_b[k] + rnd(r5_p[k]);
        end
        for (int k = 0; k < 2; k++) begin
            n7_p[k] = mul(r6_v, r6_m[2*k+1] - r6_m[2*k]);
            n8_m[k] = r7_b[k] + rnd(r7_p[k]);
        end
        n9_p    = mul(r8_w, r8_m[1] - r8_m[0]);
        n10_res = r9_b + rnd(r9_p);

        fin = (r10_res + ONE + W'(1)) >>> 1;
        if (fin < 0) begin
            fin = '0;
        end else if (fin > ONE) begin
            fin = ONE;
        end
        n_noise = fin[F:0];
    end

    always_ff @(posedge i_clk) begin
        r1_idx <= h_idx;
        r1_val <= h_val;
        r1_cy  <= h_cy;
        r1_cz  <= h_cz;
        r2_idx <= r1_idx;
        r2_val <= r1_val;
        r2_cz  <= r1_cz;
        for (int i = 0; i < 3; i++) begin
            r1_t[i]  <= n1_t[i];
            r1_pa[i] <= n1_pa[i];
            r1_pd[i] <= n1_pd[i];
            r2_t[i]  <= r1_t[i];
            r2_pc[i] <= n2_pc[i];
            r2_pe[i] <= n2_pe[i];
            r3_t[i]  <= r2_t[i];
            r3_pr[i] <= n3_pr[i];
            r4_fd[i] <= n4_fd[i];
        end
        for (int i = 0; i < 8; i++) begin
            r4_g[i] <= n4_g[i];
        end
        for (int k = 0; k < 4; k++) begin
            r5_p[k] <= n5_p[k];
            r5_b[k] <= r4_g[2*k];
            r6_m[k] <= n6_m[k];
        end
        r5_v <= r4_fd[1];
        r5_w <= r4_fd[2];
        r6_v <= r5_v;
        r6_w <= r5_w;
        for (int k = 0; k < 2; k++) begin
            r7_p[k] <= n7_p[k];
            r7_b[k] <= r6_m[2*k];
            r8_m[k] <= n8_m[k];
        end
        r7_w    <= r6_w;
        r8_w    <= r7_w;
        r9_p    <= n9_p;
        r9_b    <= r8_m[0];
        r10_res <= n10_res;
        if (owr) begin
            r_ofifo[r_owr] <= n_noise;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_cnt  <= '0;
            r_vld      <= '0;
            r_ld1      <= 1'b0;
            r_ld2      <= 1'b0;
            r_inflight <= '0;
            r_ocnt     <= '0;
            r_owr      <= '0;
            r_ord      <= '0;
        end else begin
            if (r_clr) begin
                r_clr_cnt <= IW'(r_clr_cnt + 1'b1);
                if (r_clr_cnt == IW'(TABLE_SIZE - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_vld      <= {r_vld[9:1], issue_eval};
            r_ld1      <= issue_load;
            r_ld2      <= r_ld1;
            r_inflight <= CW'(r_inflight + CW'(issue_eval) - CW'(owr));
            r_ocnt     <= CW'(r_ocnt + CW'(owr) - CW'(ord));
            if (owr) begin
                r_owr <= OAW'(r_owr + 1'b1);
            end
            if (ord) begin
                r_ord <= OAW'(r_ord + 1'b1);
            end
        end
    end

    assign o_out.valid       = (r_ocnt != '0);
    assign o_out.noise_value = r_ofifo[r_ord];

endmodule

[rtl/gradient_noise_3d_core.sv]
// ----------------------------------------------------------------------------
// gradient_noise_3d_core
// a result passes the input queue, the pipeline registers and the result fifo
// throughput: one item per cycle, held while results lack fifo space or the table clears
// the table has seven copies so all fourteen lookups of a point have their own read ports
// reset: a clearing pass loads the identity table, no transfer taken
// ----------------------------------------------------------------------------
`include "gradient_noise_3d_core_defines.svh"

module gradient_noise_3d_core #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gn3d_in_if.sink     i_in,
    gn3d_out_if.source  o_out
);

    localparam int ITEM_W = 1 + 4 * $clog2(TABLE_SIZE) + gn3d_pkg::BYTE_W + 3 * FRAC_BITS;

    gn3d_pkg::t_gn3d_qstat qstat;
    gn3d_pkg::t_gn3d_bstat bstat;
    logic                  push;
    logic                  pop;
    logic [ITEM_W-1:0]     push_item;
    logic [ITEM_W-1:0]     head_item;

    gn3d_front #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_in    (i_in),
        .i_qstat (qstat),
        .i_bstat (bstat),
        .o_push  (push),
        .o_item  (push_item)
    );

    gn3d_queue #(.WIDTH(ITEM_W), .DEPTH(gn3d_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_item),
        .i_pop    (pop),
        .o_data   (head_item),
        .o_status (qstat)
    );

    gn3d_back #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!qstat.empty),
        .i_item       (head_item),
        .o_pop        (pop),
        .o_out        (o_out),
        .o_status     (bstat)
    );

    `GN3D_ASSERT_IMP(a_no_transfer_in_clear, i_clk, i_rst_n, bstat.clearing, !i_in.ready)
    `GN3D_ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, qstat.full, !push)
    `GN3D_ASSERT_IMP(a_queue_empty_after_clear, i_clk, i_rst_n, $fell(bstat.clearing), qstat.empty)
    `GN3D_ASSERT_NXT(a_push_fills_queue, i_clk, i_rst_n, push && !pop, !qstat.empty)

endmodule

[test/gn3d_noise_checker.sv]
// ----------------------------------------------------------------------------
// gradient noise result checker
// watches both channels, keeps its own permutation table, computes the
// expected noise value of each evaluate transfer and compares it in order
// ----------------------------------------------------------------------------
module gn3d_noise_checker #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gn3d_in_if   i_in,
    gn3d_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);

    localparam longint ONE = longint'(1) << FRAC_BITS;

    logic [7:0]         perm [TABLE_SIZE];
    logic [FRAC_BITS:0] noise_queue [$];

    function automatic longint fx_mul(longint a, longint b);
        return (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint fade(longint t);
        longint a, b, c, d, e, r;
        a = 6 * t - 15 * ONE;
        b = fx_mul(t, a) + 10 * ONE;
        c = fx_mul(t, b);
        d = fx_mul(t, t);
        e = fx_mul(d, t);
        r = fx_mul(e, c);
        if (r < 0) r = 0;
        if (r > ONE) r = ONE;
        return r;
    endfunction

    function automatic longint blend(longint t, longint a, longint b);
        return a + fx_mul(t, b - a);
    endfunction

    function automatic longint grad(int hash, longint gx, longint gy, longint gz);
        logic [3:0] h;
        longint     u, v;
        h = hash[3:0];
        u = (h < 8) ? gx : gy;
        v = (h < 4) ? gy : ((h == 12 || h == 14) ? gx : gz);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic int hash_at(int i);
        return int'(perm[i % TABLE_SIZE]);
    endfunction

    function automatic logic [FRAC_BITS:0] noise_at(logic signed [31:0] px,
                                                    logic signed [31:0] py,
                                                    logic signed [31:0] pz);
        int     cx, cy, cz, a, aa, ab, b, ba, bb;
        longint fx, fy, fz, u, v, w, x1, y1, z1, res, val;
        cx = int'((longint'(px) >>> FRAC_BITS) & (TABLE_SIZE - 1));
        cy = int'((longint'(py) >>> FRAC_BITS) & (TABLE_SIZE - 1));
        cz = int'((longint'(pz) >>> FRAC_BITS) & (TABLE_SIZE - 1));
        fx = longint'(px) & (ONE - 1);
        fy = longint'(py) & (ONE - 1);
        fz = longint'(pz) & (ONE - 1);
        u = fade(fx);
        v = fade(fy);
        w = fade(fz);
        a  = (hash_at(cx) + cy) % TABLE_SIZE;
        aa = (hash_at(a) + cz) % TABLE_SIZE;
        ab = (hash_at(a + 1) + cz) % TABLE_SIZE;
        b  = (hash_at(cx + 1) + cy) % TABLE_SIZE;
        ba = (hash_at(b) + cz) % TABLE_SIZE;
        bb = (hash_at(b + 1) + cz) % TABLE_SIZE;
        x1 = fx - ONE;
        y1 = fy - ONE;
        z1 = fz - ONE;
        res = blend(w,
                    blend(v,
                          blend(u, grad(hash_at(aa), fx, fy, fz), grad(hash_at(ba), x1, fy, fz)),
                          blend(u, grad(hash_at(ab), fx, y1, fz), grad(hash_at(bb), x1, y1, fz))),
                    blend(v,
                          blend(u, grad(hash_at(aa + 1), fx, fy, z1),
                                grad(hash_at(ba + 1), x1, fy, z1)),
                          blend(u, grad(hash_at(ab + 1), fx, y1, z1),
                                grad(hash_at(bb + 1), x1, y1, z1))));
        val = (res + ONE + 1) >>> 1;
        if (val < 0) val = 0;
        if (val > ONE) val = ONE;
        return val[FRAC_BITS:0];
    endfunction

    assign o_pending = noise_queue.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) perm[i] = 8'(i);
            noise_queue.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (noise_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, i_out.noise_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (i_out.noise_value !== noise_queue[0]) begin
                        $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                                 $time, noise_queue[0], i_out.noise_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(noise_queue.pop_front());
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (gn3d_pkg::t_gn3d_kind'(i_in.kind) == gn3d_pkg::KIND_LOAD)
                    perm[i_in.table_index % TABLE_SIZE] = i_in.table_value;
                else
                    noise_queue.push_back(noise_at(i_in.x_coord, i_in.y_coord, i_in.z_coord));
            end
        end
    end
endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// gradient noise core testbench
// directed corner points and table loads, then random loads and evaluations
// with random idling on both channels, checked in order by the checker
// ----------------------------------------------------------------------------
module tb;

    localparam int LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycles = 0;
    int   fails;
    int   pending;
    int   sent = 0;
    bit   hold_done = 1'b0;

    gn3d_in_if  in_ch ();
    gn3d_out_if #(.FRAC_BITS(16)) out_ch ();

    gradient_noise_3d_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gn3d_noise_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send(gn3d_pkg::t_gn3d_kind kind, logic [7:0] idx, logic [7:0] value,
                        logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= kind;
        in_ch.table_index <= idx;
        in_ch.table_value <= value;
        in_ch.x_coord     <= px;
        in_ch.y_coord     <= py;
        in_ch.z_coord     <= pz;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
        if (!(sent >= 500 && sent < 650) && $urandom_range(99) < 27) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic eval_at(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        send(gn3d_pkg::KIND_EVAL, 8'($urandom), 8'($urandom), px, py, pz);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(65535)) - 32'h0000_8000 + ($urandom << 16);
            2: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
            default: return {16'($urandom_range(3)) - 16'd1, 16'($urandom)};
        endcase
    endfunction

    // receiver: random stalls, one long hold-off, a stretch always ready
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && sent >= 200) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end
            if (sent >= 300 && sent < 450) out_ch.ready <= 1'b1;
            else out_ch.ready <= ($urandom_range(99) >= 21);
        end
    end

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.kind        <= gn3d_pkg::KIND_EVAL;
        in_ch.table_index <= '0;
        in_ch.table_value <= '0;
        in_ch.x_coord     <= '0;
        in_ch.y_coord     <= '0;
        in_ch.z_coord     <= '0;
        i_rst_n           <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity table first
        eval_at(32'h0, 32'h0, 32'h0);
        eval_at(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        eval_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        eval_at(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        eval_at(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        eval_at(32'h0001_0000, 32'hffff_0000, 32'h00ff_0000);
        eval_at(32'hfffe_4000, 32'h0003_c000, 32'h8000_ffff);
        eval_at(32'h0000_ffff, 32'h0000_0001, 32'h7fff_0000);
        eval_at(32'h0000_4000, 32'h0000_c000, 32'h0000_2000);
        // loads: extremes of index and value and two more entries, coordinates ignored
        send(gn3d_pkg::KIND_LOAD, 8'd0, 8'd255, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send(gn3d_pkg::KIND_LOAD, 8'd255, 8'd0, 32'h0, 32'h0, 32'h0);
        send(gn3d_pkg::KIND_LOAD, 8'd1, 8'd15, 32'h0, 32'h0, 32'h0);
        send(gn3d_pkg::KIND_LOAD, 8'd128, 8'd14, 32'h0, 32'h0, 32'h0);
        eval_at(32'h0, 32'h0, 32'h0);
        eval_at(32'h00ff_8000, 32'h00ff_8000, 32'h00ff_8000);
        eval_at(32'hffff_8000, 32'h0000_8000, 32'hffff_0000);
        for (int h = 0; h < 8; h++) begin
            send(gn3d_pkg::KIND_LOAD, 8'(h), 8'(12 + h), 32'h0, 32'h0, 32'h0);
            eval_at(32'h0000_3000, 32'h0000_a000, 32'h0000_6000);
        end

        while (sent < 870) begin
            if (sent == 520) begin
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            if ($urandom_range(99) < 15)
                send(gn3d_pkg::KIND_LOAD, 8'($urandom), 8'($urandom),
                     $urandom, $urandom, $urandom);
            else
                eval_at(rand_coord(), rand_coord(), rand_coord());
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fails == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/gn3d_pkg.sv
rtl/gn3d_if.sv
rtl/gn3d_ram.sv
rtl/gn3d_queue.sv
rtl/gn3d_front.sv
rtl/gn3d_back.sv
rtl/gradient_noise_3d_core.sv
test/gn3d_noise_checker.sv
test/tb.sv
